[hw/rtl/nkh_pkg.sv]
// Shared types and codes for the node key hash table.
package nkh_pkg;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } nkh_op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_BUSY     = 2'd2,
    ST_FULL     = 2'd3
  } nkh_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_req;    // capture the request, read the bucket head
    logic        clr_wr;      // write one empty bucket head
    logic        take_head;   // start the walk at the head
    logic        ent_rd;      // read the entry at the walk position
    logic        step;        // advance the walk to the next link
    logic        pop_rd;      // read the top of the free stack
    logic        take_pop;    // allocate the entry popped from the stack
    logic        take_alloc;  // allocate a never used entry
    logic        ins_wr;      // write the new entry
    logic        link_wr;     // link the new entry at the chain tail
    logic        unlink_wr;   // unlink the matched entry and free it
    logic        res_load;    // load the result register
    nkh_status_e res_status;
    logic        res_handle;  // report the matched entry handle
  } nkh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    nkh_op_e op;
    logic    clr_last;
    logic    cur_nil;
    logic    hit;
    logic    stack_empty;
    logic    pool_full;
    logic    out_busy;
  } nkh_stat_t;

endpackage

[hw/rtl/nkh_if.sv]
// Request and result channel interfaces of the node key hash table.
interface nkh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] device_major;
  logic [19:0] device_minor;
  logic [31:0] inode_number;
  logic [31:0] node_handle;

  modport source (output valid, operation, device_major, device_minor, inode_number,
                  node_handle, input ready);
  modport sink (input valid, operation, device_major, device_minor, inode_number,
                node_handle, output ready);
endinterface

interface nkh_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_handle;

  modport source (output valid, status, found_handle, input ready);
  modport sink (input valid, status, found_handle, output ready);
endinterface

[hw/rtl/nkh_datapath.sv]
// Datapath of the node key hash table: request registers, memories and walk pointers.
module nkh_datapath import nkh_pkg::*; #(
  parameter int BUCKETS      = 256,
  parameter int POOL_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  nkh_cmd_t    cmd_i,
  output nkh_stat_t   stat_o,
  input  logic [1:0]  operation_i,
  input  logic [11:0] device_major_i,
  input  logic [19:0] device_minor_i,
  input  logic [31:0] inode_number_i,
  input  logic [31:0] node_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] found_handle_o
);

  localparam int BW = $clog2(BUCKETS);
  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int PW = $clog2(POOL_ENTRIES + 1);
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);
  localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);

  // Memories.
  logic [PW-1:0] head_mem [BUCKETS];
  logic [95:0]   ent_mem  [POOL_ENTRIES];
  logic [PW-1:0] next_mem [POOL_ENTRIES];
  logic [IW-1:0] stk_mem  [POOL_ENTRIES];

  // Control registers.
  logic [BW-1:0] clr_q;
  logic [PW-1:0] alloc_q, sp_q;
  logic          out_valid_q;

  // Payload registers.
  nkh_op_e       op_q;
  logic [31:0]   dev_q, ino_q, hnd_q;
  logic [BW-1:0] bkt_q;
  logic [PW-1:0] cur_q, prev_q;
  logic [IW-1:0] f_q;
  logic [PW-1:0] head_rdata_q, nxt_rdata_q;
  logic [95:0]   ent_rdata_q;
  logic [IW-1:0] stk_rdata_q;
  logic [1:0]    res_status_q;
  logic [31:0]   res_hnd_q;

  logic [31:0]   in_sum;
  logic [BW-1:0] in_bkt;
  logic          prev_nil;
  logic [PW-1:0] sp_m1;
  logic          hit;

  // Bucket of the incoming key.
  assign in_sum   = {12'd0, device_minor_i} + inode_number_i;
  assign in_bkt   = in_sum[BW-1:0] & BMASK;
  assign prev_nil = (prev_q == NIL);
  assign sp_m1    = sp_q - PW'(1);
  assign hit      = (ent_rdata_q[95:64] == dev_q) && (ent_rdata_q[63:32] == ino_q);

  // Status to the controller.
  assign stat_o.op          = op_q;
  assign stat_o.clr_last    = (clr_q == BMASK);
  assign stat_o.cur_nil     = (cur_q == NIL);
  assign stat_o.hit         = hit;
  assign stat_o.stack_empty = (sp_q == '0);
  assign stat_o.pool_full   = (alloc_q == NIL);
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      alloc_q     <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + BW'(1);
      if (cmd_i.take_alloc) alloc_q <= alloc_q + PW'(1);
      if (cmd_i.take_pop) begin
        sp_q <= sp_m1;
      end else if (cmd_i.unlink_wr) begin
        sp_q <= sp_q + PW'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, walk pointers and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= nkh_op_e'(operation_i);
      dev_q <= {device_major_i, device_minor_i};
      ino_q <= inode_number_i;
      hnd_q <= node_handle_i;
      bkt_q <= in_bkt;
    end
    if (cmd_i.take_head) begin
      cur_q  <= head_rdata_q;
      prev_q <= NIL;
    end else if (cmd_i.step) begin
      cur_q  <= nxt_rdata_q;
      prev_q <= cur_q;
    end
    if (cmd_i.take_pop) begin
      f_q <= stk_rdata_q;
    end else if (cmd_i.take_alloc) begin
      f_q <= alloc_q[IW-1:0];
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_hnd_q    <= cmd_i.res_handle ? ent_rdata_q[31:0] : 32'd0;
    end
  end

  // Bucket head memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      head_mem[clr_q] <= NIL;
    end else if (cmd_i.link_wr && prev_nil) begin
      head_mem[bkt_q] <= PW'(f_q);
    end else if (cmd_i.unlink_wr && prev_nil) begin
      head_mem[bkt_q] <= nxt_rdata_q;
    end
    if (cmd_i.load_req) head_rdata_q <= head_mem[in_bkt];
  end

  // Entry key and handle memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) ent_mem[f_q] <= {dev_q, ino_q, hnd_q};
    if (cmd_i.ent_rd) ent_rdata_q <= ent_mem[cur_q[IW-1:0]];
  end

  // Link memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) begin
      next_mem[f_q] <= NIL;
    end else if (cmd_i.link_wr && !prev_nil) begin
      next_mem[prev_q[IW-1:0]] <= PW'(f_q);
    end else if (cmd_i.unlink_wr && !prev_nil) begin
      next_mem[prev_q[IW-1:0]] <= nxt_rdata_q;
    end
    if (cmd_i.ent_rd) nxt_rdata_q <= next_mem[cur_q[IW-1:0]];
  end

  // Free entry stack.
  always_ff @(posedge clk_i) begin
    if (cmd_i.unlink_wr) stk_mem[sp_q[IW-1:0]] <= cur_q[IW-1:0];
    if (cmd_i.pop_rd) stk_rdata_q <= stk_mem[sp_m1[IW-1:0]];
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_status_q;
  assign found_handle_o = res_hnd_q;

endmodule

[hw/rtl/nkh_ctrl.sv]
// Controller state machine of the node key hash table.
module nkh_ctrl import nkh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nkh_stat_t stat_i,
  output nkh_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_CHECK, S_COMPARE, S_POP, S_TAKE,
    S_INS_WR, S_INS_LINK, S_UNLINK, S_DONE
  } state_e;

  state_e      state_q, state_d;
  nkh_status_e res_q, res_d;
  logic        use_hnd_q, use_hnd_d;

  logic miss, decide;

  assign miss   = (state_q == S_CHECK) && stat_i.cur_nil;
  assign decide = miss || ((state_q == S_COMPARE) && stat_i.hit);

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    use_hnd_d = use_hnd_q;
    cmd_o     = '0;
    cmd_o.res_status = res_q;
    cmd_o.res_handle = use_hnd_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_o.take_head = 1'b1;
        state_d         = S_CHECK;
      end
      S_CHECK: begin
        if (!stat_i.cur_nil) begin
          cmd_o.ent_rd = 1'b1;
          state_d      = S_COMPARE;
        end
      end
      S_COMPARE: begin
        if (!stat_i.hit) begin
          cmd_o.step = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_POP: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.take_pop = 1'b1;
        state_d        = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd_o.link_wr = 1'b1;
        res_d         = ST_OK;
        use_hnd_d     = 1'b0;
        state_d       = S_DONE;
      end
      S_UNLINK: begin
        cmd_o.unlink_wr = 1'b1;
        res_d           = ST_OK;
        use_hnd_d       = 1'b0;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // End of the walk: choose the outcome of the operation.
    if (decide) begin
      res_d     = ST_NOTFOUND;
      use_hnd_d = 1'b0;
      state_d   = S_DONE;
      case (stat_i.op)
        OP_LOOKUP: begin
          if (!miss) begin
            res_d     = ST_OK;
            use_hnd_d = 1'b1;
          end
        end
        OP_INSERT: begin
          if (!miss) begin
            res_d = ST_BUSY;
          end else if (!stat_i.stack_empty) begin
            state_d = S_POP;
          end else if (stat_i.pool_full) begin
            res_d = ST_FULL;
          end else begin
            cmd_o.take_alloc = 1'b1;
            state_d          = S_INS_WR;
          end
        end
        OP_REMOVE: begin
          if (!miss) state_d = S_UNLINK;
        end
        default: res_d = ST_NOTFOUND;
      endcase
    end
  end

  // State and registered result code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      res_q     <= ST_NOTFOUND;
      use_hnd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_q     <= res_d;
      use_hnd_q <= use_hnd_d;
    end
  end

endmodule

[hw/rtl/node_key_hash_table.sv]
// Top level of the node key hash table.
//
//   Channel   Direction  Handshake      Payload
//   req       in         valid / ready  operation, device_major, device_minor,
//                                       inode_number, node_handle
//   rsp       out        valid / ready  status, found_handle
//
// A request passes through the controller states IDLE, HEAD and CHECK and ends in DONE;
// each chain entry visited costs one entry memory read (CHECK) and one compare (COMPARE).
// An insert that misses adds INS_WR and INS_LINK (after POP and TAKE when a freed entry
// is reused from the free stack) and a remove that hits adds UNLINK. After reset the
// bucket heads are cleared one per cycle, and no request is accepted until all are clear.
// A waiting result in the output register stalls only the final step of the next request.
module node_key_hash_table import nkh_pkg::*; #(
  parameter int BUCKETS      = 256,
  parameter int POOL_ENTRIES = 256
) (
  input logic       clk_i,
  input logic       rst_ni,
  nkh_req_if.sink   req,
  nkh_rsp_if.source rsp
);

  nkh_cmd_t  cmd;
  nkh_stat_t stat;

  nkh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nkh_datapath #(
    .BUCKETS      (BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .operation_i    (req.operation),
    .device_major_i (req.device_major),
    .device_minor_i (req.device_minor),
    .inode_number_i (req.inode_number),
    .node_handle_i  (req.node_handle),
    .out_valid_o    (rsp.valid),
    .out_ready_i    (rsp.ready),
    .status_o       (rsp.status),
    .found_handle_o (rsp.found_handle)
  );

endmodule
